>>> rtl/pic_pkg.sv
// pic_pkg: widths, codes, reset values and shared types of the pi position controller
// no dependencies; compiled first
`timescale 1ns / 1ps

package pic_pkg;

   // field widths
   localparam int POS_W      = 32;
   localparam int DT_W       = 16;
   localparam int ERR_W      = POS_W + 1;
   localparam int INTEG_W    = 56;
   localparam int GAIN_W     = 24;
   localparam int LIMIT_W    = 15;
   localparam int DRIVE_W    = 16;
   localparam int STATE_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // serial multiplier geometry: signed multiplicand, unsigned multiplier bits
   localparam int MULA_W  = INTEG_W;
   localparam int MULB_W  = GAIN_W;
   localparam int PROD_W  = MULA_W + 1 + MULB_W;
   localparam int CNT_W   = $clog2(MULB_W + 1);
   localparam int PTERM_W = ERR_W + GAIN_W;
   localparam int TERM_W  = 64;

   // opcodes
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT = 2'd2;

   // limit state codes
   localparam logic [STATE_W-1:0] LIM_NONE = 2'd0;
   localparam logic [STATE_W-1:0] LIM_HIGH = 2'd1;
   localparam logic [STATE_W-1:0] LIM_LOW  = 2'd2;

   // reset values
   localparam logic [GAIN_W-1:0]  PROP_GAIN_RESET   = 24'd65536;
   localparam logic [GAIN_W-1:0]  INTEG_GAIN_RESET  = 24'd0;
   localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RESET = 15'd32767;

   // integrator saturation bounds
   localparam logic [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

   // integral term saturates at +/- 2^62
   localparam logic signed [PROD_W-1:0] TERM_SAT_POS = {{(PROD_W-63){1'b0}}, 1'b1, 62'd0};
   localparam logic signed [PROD_W-1:0] TERM_SAT_NEG = {{(PROD_W-62){1'b1}}, 62'd0};

   typedef struct packed {
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  integ_gain;
      logic [LIMIT_W-1:0] drive_limit;
   } gains_type;

   typedef struct packed {
      logic [DRIVE_W-1:0] drive;
      logic [STATE_W-1:0] limit_state;
   } result_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] steps;
   } mul_ctrl_type;

endpackage

>>> rtl/pic_if.sv
// pic_if: valid/ready channel interfaces for request, response and register writes
// depends on pic_pkg
`timescale 1ns / 1ps

interface pic_req_if;
   import pic_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    opcode;
   logic signed [POS_W-1:0] target_position;
   logic signed [POS_W-1:0] measured_position;
   logic [DT_W-1:0]         time_step;

   modport source (output valid, opcode, target_position, measured_position, time_step,
                   input ready);
   modport sink (input valid, opcode, target_position, measured_position, time_step,
                 output ready);
endinterface

interface pic_rsp_if;
   import pic_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive;
   logic [STATE_W-1:0]        limit_state;

   modport source (output valid, drive, limit_state, input ready);
   modport sink (input valid, drive, limit_state, output ready);
endinterface

interface pic_csr_if;
   import pic_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

>>> rtl/pic_serial_mult.sv
// pic_serial_mult: shift-add multiplier, one multiplier bit per cycle, lsb first
// depends on pic_pkg
`timescale 1ns / 1ps

module pic_serial_mult (
   input  logic                        clock,
   input  logic                        reset,
   input  pic_pkg::mul_ctrl_type       ctrl,
   input  logic [pic_pkg::MULA_W-1:0]  mcand,
   input  logic [pic_pkg::MULB_W-1:0]  mplier,
   output logic                        done,
   output logic [pic_pkg::MULA_W:0]    prod_hi,
   output logic [pic_pkg::MULB_W-1:0]  prod_lo
);
   import pic_pkg::*;

   logic [MULA_W-1:0] mcand_ff, mcand_in;
   logic [MULA_W:0]   acc_ff, acc_in;
   logic [MULB_W-1:0] shr_ff, shr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [MULA_W+1:0] sum;

   always_comb begin
      // partial sum, one guard bit above the sign
      sum = {acc_ff[MULA_W], acc_ff}
          + (shr_ff[0] ? {{2{mcand_ff[MULA_W-1]}}, mcand_ff} : '0);
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      shr_in   = shr_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (ctrl.start) begin
         mcand_in = mcand;
         acc_in   = '0;
         shr_in   = mplier;
         cnt_in   = ctrl.steps;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // low product bit drops into the top of the multiplier register
         acc_in = sum[MULA_W+1:1];
         shr_in = {sum[0], shr_ff[MULB_W-1:1]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
      shr_ff   <= shr_in;
      cnt_ff   <= cnt_in;
   end

   assign done    = done_ff;
   assign prod_hi = acc_ff;
   assign prod_lo = shr_ff;

endmodule

>>> rtl/pic_core.sv
// pic_core: update sequencer, integrator with saturation, clamp and anti-windup undo
// depends on pic_pkg and pic_serial_mult
`timescale 1ns / 1ps

module pic_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_accept,
   input  logic                             req_opcode,
   input  logic signed [pic_pkg::POS_W-1:0] req_target,
   input  logic signed [pic_pkg::POS_W-1:0] req_measured,
   input  logic [pic_pkg::DT_W-1:0]         req_time_step,
   input  pic_pkg::gains_type               gains,
   input  logic                             out_free,
   output logic                             idle,
   output logic                             out_load,
   output pic_pkg::result_type              result
);
   import pic_pkg::*;

   localparam int RAW_W = TERM_W - FRAC_BITS;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_MUL_INC = 3'd1;
   localparam logic [2:0] S_SUM     = 3'd2;
   localparam logic [2:0] S_MUL_P   = 3'd3;
   localparam logic [2:0] S_MUL_I   = 3'd4;
   localparam logic [2:0] S_ADD     = 3'd5;
   localparam logic [2:0] S_DONE    = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic                    clr_ff, clr_in;
   logic [INTEG_W-1:0]      integ_ff, integ_in;
   logic [INTEG_W-1:0]      new_integ_ff, new_integ_in;
   logic [ERR_W-1:0]        err_ff, err_in;
   logic [PTERM_W-1:0]      pterm_ff, pterm_in;
   logic [TERM_W-1:0]       iterm_ff, iterm_in;
   logic signed [RAW_W-1:0] raw_ff, raw_in;

   mul_ctrl_type      mul_ctrl;
   logic [MULA_W-1:0] mul_mcand;
   logic [MULB_W-1:0] mul_mplier;
   logic              mul_done;
   logic [MULA_W:0]   mul_hi;
   logic [MULB_W-1:0] mul_lo;

   logic [ERR_W-1:0]         diff;
   logic [INTEG_W:0]         integ_sum;
   logic [INTEG_W-1:0]       integ_sat;
   logic signed [PROD_W-1:0] prod;
   logic [TERM_W-1:0]        iterm_sat;
   logic [TERM_W-1:0]        term_sum;
   logic signed [RAW_W-1:0]  lim_ext;
   logic [DRIVE_W-1:0]       lim16;
   logic                     clamp_high;
   logic                     clamp_low;
   logic                     undo;

   pic_serial_mult u_mult (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mul_ctrl),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .done    (mul_done),
      .prod_hi (mul_hi),
      .prod_lo (mul_lo)
   );

   // datapath arithmetic
   always_comb begin
      diff = {req_target[POS_W-1], req_target} - {req_measured[POS_W-1], req_measured};

      integ_sum = {integ_ff[INTEG_W-1], integ_ff} + mul_hi;
      case (integ_sum[INTEG_W:INTEG_W-1])
         2'b01:   integ_sat = INTEG_MAX;
         2'b10:   integ_sat = INTEG_MIN;
         default: integ_sat = integ_sum[INTEG_W-1:0];
      endcase

      prod = {mul_hi, mul_lo};
      if (prod > TERM_SAT_POS) begin
         iterm_sat = TERM_SAT_POS[TERM_W-1:0];
      end else if (prod < TERM_SAT_NEG) begin
         iterm_sat = TERM_SAT_NEG[TERM_W-1:0];
      end else begin
         iterm_sat = prod[TERM_W-1:0];
      end

      term_sum = {{(TERM_W-PTERM_W){pterm_ff[PTERM_W-1]}}, pterm_ff} + iterm_ff;

      lim_ext    = {{(RAW_W-LIMIT_W){1'b0}}, gains.drive_limit};
      lim16      = {1'b0, gains.drive_limit};
      clamp_high = raw_ff > lim_ext;
      clamp_low  = raw_ff < -lim_ext;
      undo       = (clamp_high && !err_ff[ERR_W-1] && (err_ff != '0))
                || (clamp_low && err_ff[ERR_W-1]);
   end

   // multiplier launch: dt*err, then kp*err, then ki*integrator
   always_comb begin
      mul_ctrl   = '0;
      mul_mcand  = '0;
      mul_mplier = '0;
      case (state_ff)
         S_IDLE: begin
            mul_ctrl.start = req_accept && (req_opcode == OP_UPDATE);
            mul_ctrl.steps = CNT_W'(DT_W);
            mul_mcand      = {{(MULA_W-ERR_W){diff[ERR_W-1]}}, diff};
            mul_mplier     = {{(MULB_W-DT_W){1'b0}}, req_time_step};
         end
         S_SUM: begin
            mul_ctrl.start = 1'b1;
            mul_ctrl.steps = CNT_W'(GAIN_W);
            mul_mcand      = {{(MULA_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
            mul_mplier     = gains.prop_gain;
         end
         S_MUL_P: begin
            mul_ctrl.start = mul_done;
            mul_ctrl.steps = CNT_W'(GAIN_W);
            mul_mcand      = new_integ_ff;
            mul_mplier     = gains.integ_gain;
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      integ_in     = integ_ff;
      new_integ_in = new_integ_ff;
      err_in       = err_ff;
      pterm_in     = pterm_ff;
      iterm_in     = iterm_ff;
      raw_in       = raw_ff;
      out_load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_opcode == OP_CLEAR) begin
                  clr_in   = 1'b1;
                  integ_in = '0;
                  state_in = S_DONE;
               end else begin
                  clr_in   = 1'b0;
                  err_in   = diff;
                  state_in = S_MUL_INC;
               end
            end
         end
         S_MUL_INC: begin
            if (mul_done) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            new_integ_in = integ_sat;
            state_in     = S_MUL_P;
         end
         S_MUL_P: begin
            if (mul_done) begin
               pterm_in = prod[PTERM_W-1:0];
               state_in = S_MUL_I;
            end
         end
         S_MUL_I: begin
            if (mul_done) begin
               iterm_in = iterm_sat;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            raw_in   = term_sum[TERM_W-1:FRAC_BITS];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               if (!clr_ff) begin
                  integ_in = undo ? integ_ff : new_integ_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (clr_ff) begin
         result.drive       = '0;
         result.limit_state = LIM_NONE;
      end else if (clamp_high) begin
         result.drive       = lim16;
         result.limit_state = LIM_HIGH;
      end else if (clamp_low) begin
         result.drive       = '0 - lim16;
         result.limit_state = LIM_LOW;
      end else begin
         result.drive       = raw_ff[DRIVE_W-1:0];
         result.limit_state = LIM_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         clr_ff   <= 1'b0;
         integ_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      new_integ_ff <= new_integ_in;
      err_ff       <= err_in;
      pterm_ff     <= pterm_in;
      iterm_ff     <= iterm_in;
      raw_ff       <= raw_in;
   end

   assign idle = (state_ff == S_IDLE);

endmodule

>>> rtl/pi_position_controller.sv
// pi_position_controller: top level, register file, response register and core
// depends on pic_pkg, pic_if and pic_core
//
// usage
// - req_bus carries one update (opcode 0) or clear (opcode 1) per transfer; target and
//   measured position are signed q16.16, time_step is unsigned q0.16 seconds
// - rsp_bus returns exactly one transfer per request: drive (signed q1.15) and
//   limit_state (0 within limit, 1 clamped high, 2 clamped low)
// - csr_bus writes prop_gain (index 0), integ_gain (index 1) and drive_limit (index 2);
//   it is always ready, other indexes are dropped; write only while no request is open
// - requests do not overlap, as one is taken only while the core is idle; an update runs
//   one shared bit-serial multiplier for dt*error over the 16 bits of dt, then for
//   kp*error and ki*integrator over the 24 bits of each gain, then the sum and clamp states
// - a clear goes straight to S_DONE, loads the response register once it frees and
//   zeroes the integrator
// - a finished result sits in the response register; the core can take and work on the
//   next request while rsp is stalled, and holds its own result until the register frees
// - reset (synchronous) clears the integrator, loads the register reset values and
//   empties the response register
`timescale 1ns / 1ps

module pi_position_controller #(
   parameter int FRAC_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   pic_req_if.sink   req_bus,
   pic_rsp_if.source rsp_bus,
   pic_csr_if.sink   csr_bus
);
   import pic_pkg::*;

   gains_type  gains_ff, gains_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   logic       core_idle;
   logic       core_load;
   result_type core_result;
   logic       req_accept;
   logic       out_free;

   // request transfer only when the core is waiting
   assign req_bus.ready = core_idle;
   assign req_accept    = req_bus.valid && req_bus.ready;

   // response register may load when empty or emptying this cycle
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   pic_core #(
      .FRAC_BITS (FRAC_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .req_opcode    (req_bus.opcode),
      .req_target    (req_bus.target_position),
      .req_measured  (req_bus.measured_position),
      .req_time_step (req_bus.time_step),
      .gains         (gains_ff),
      .out_free      (out_free),
      .idle          (core_idle),
      .out_load      (core_load),
      .result        (core_result)
   );

   // register writes, always accepted
   assign csr_bus.ready = 1'b1;

   always_comb begin
      gains_in = gains_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.reg_index)
            CSR_PROP_GAIN:   gains_in.prop_gain   = csr_bus.wdata;
            CSR_INTEG_GAIN:  gains_in.integ_gain  = csr_bus.wdata;
            CSR_DRIVE_LIMIT: gains_in.drive_limit = csr_bus.wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.prop_gain   <= PROP_GAIN_RESET;
         gains_ff.integ_gain  <= INTEG_GAIN_RESET;
         gains_ff.drive_limit <= DRIVE_LIMIT_RESET;
         rsp_valid_ff         <= 1'b0;
      end else begin
         gains_ff     <= gains_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.drive       = rsp_data_ff.drive;
   assign rsp_bus.limit_state = rsp_data_ff.limit_state;

endmodule

>>> rtl/pic_checker.sv
// pic_checker: port-level assertions for the pi position controller, bound to the top
// depends on pic_pkg and pi_position_controller
`timescale 1ns / 1ps

module pic_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [pic_pkg::DRIVE_W-1:0] drive,
   input logic [pic_pkg::STATE_W-1:0]        limit_state
);
   import pic_pkg::*;

   // stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(drive) && $stable(limit_state))
      else $error("response changed while stalled");

   // only the three defined limit states appear
   a_state_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (limit_state == LIM_NONE || limit_state == LIM_HIGH
                     || limit_state == LIM_LOW))
      else $error("undefined limit state");

   // clamp side matches drive sign
   a_clamp_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (limit_state != LIM_HIGH || drive >= 0)
                 && (limit_state != LIM_LOW || drive <= 0))
      else $error("clamp side disagrees with drive sign");

   // one request in flight: after a transfer the request side closes
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken on consecutive cycles");

   // no response straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind pi_position_controller pic_checker u_pic_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .drive       (rsp_bus.drive),
   .limit_state (rsp_bus.limit_state)
);
